>>> rtl/core/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants for the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int SeqBits       = 16;
  localparam int BaseW         = SeqBits + 1;
  localparam int WinRegW       = 5;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 16;
  localparam int WindowMaxDef  = 16;

  // event codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // config register indexes
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LAST_SEQ    = 1'd1;

  localparam logic [WinRegW-1:0] WindowSizeRst = 5'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SeqBits-1:0] ack_seq;
  } srsw_in_t;

  typedef struct packed {
    logic               send_valid;
    logic [SeqBits-1:0] tx_seq;
    logic               is_resend;
    logic [BaseW-1:0]   window_base;
    logic               done_res;
    logic               last;
  } srsw_out_t;

  // per-cell control
  typedef struct packed {
    logic clear;
    logic shift;
  } srsw_cell_ctl_t;

endpackage

>>> rtl/core/srsw_cell.sv
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot: holds the acked bit, takes its upper neighbor on a slide.
// ----------------------------------------------------------------------------
module srsw_cell
  import srsw_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srsw_cell_ctl_t ctl_i,
  input  logic           set_i,
  input  logic           nbr_i,
  output logic           acked_o
);

  logic acked_q, acked_d;

  always_comb begin
    acked_d = acked_q;
    if (ctl_i.clear) begin
      acked_d = 1'b0;
    end else if (ctl_i.shift) begin
      acked_d = nbr_i;
    end else if (set_i) begin
      acked_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q <= 1'b0;
    end else begin
      acked_q <= acked_d;
    end
  end

  assign acked_o = acked_q;

endmodule

>>> rtl/core/selective_repeat_send_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_send_window
// Sender-side window tracker for selective-repeat ARQ.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
//   beat: start, ack of a sequence number, or timeout. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one or more result beats
//   per event; the final beat of an event has last set.
//   Configuration (cfg_valid_i / cfg_ready_o) writes window_size (index 0)
//   and last_seq (index 1); write only while the block is idle.
// Operation:
//   One event at a time. An event is accepted; on an ack of the base the acked
//   bits then step down the cell chain one slot per cycle until the end of the
//   run is seen. The result beats then go out through the single output
//   register, each waiting while the output stalls.
// Reset: window empty, base = next = 0, window_size = 4, last_seq = 0.
// A stalled output beat holds; emission of further beats waits for it, and
// a new event can be accepted while the final beat still waits.
// ----------------------------------------------------------------------------
module selective_repeat_send_window
  import srsw_pkg::*;
#(
  parameter int WINDOW_MAX = WindowMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srsw_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srsw_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int KW = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SLIDE  = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_RESEND = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [BaseW-1:0]   base_q, base_d;
  logic [BaseW-1:0]   next_q, next_d;
  logic [KW-1:0]      k_q, k_d;
  logic [WinRegW-1:0] win_size_q;
  logic [SeqBits-1:0] last_seq_q;
  logic               out_valid_q, out_valid_d;
  srsw_out_t          out_q, out_d;

  logic [WINDOW_MAX-1:0] acked;
  logic [WINDOW_MAX-1:0] set_vec;
  srsw_cell_ctl_t        cell_ctl;

  logic               in_acc;
  logic               slot_free;
  logic [BaseW-1:0]   ack17, diff_ack, diff, last17, win17;
  logic [7:0]         ws8, win_eff8;
  logic               ack_in_range;
  logic [KW-1:0]      k_nx;
  logic               can_send, more_after;
  logic               done_now;

  // ---- configuration ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WindowSizeRst;
      last_seq_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_SIZE: win_size_q <= cfg_data_i[WinRegW-1:0];
        REG_LAST_SEQ:    last_seq_q <= cfg_data_i[SeqBits-1:0];
        default: ;
      endcase
    end
  end

  // effective window: 0 acts as 1, clamp at WINDOW_MAX
  assign ws8 = 8'(win_size_q);
  always_comb begin
    if (ws8 == 8'd0) begin
      win_eff8 = 8'd1;
    end else if (ws8 > 8'(WINDOW_MAX)) begin
      win_eff8 = 8'(WINDOW_MAX);
    end else begin
      win_eff8 = ws8;
    end
  end
  assign win17  = BaseW'(win_eff8);
  assign last17 = BaseW'(last_seq_q);

  // ---- handshakes ----
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // ---- ack range check ----
  assign ack17        = BaseW'(in_data_i.ack_seq);
  assign ack_in_range = (ack17 >= base_q) && (ack17 < next_q);
  assign diff_ack     = ack17 - base_q;

  // ---- cell chain ----
  assign cell_ctl.clear = in_acc && (in_data_i.opcode == OP_START);
  assign cell_ctl.shift = (state_q == S_SLIDE) && acked[0];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic nbr;
    if (i == WINDOW_MAX - 1) begin : g_top
      assign nbr = 1'b0;
    end else begin : g_mid
      assign nbr = acked[i+1];
    end
    assign set_vec[i] = in_acc && (in_data_i.opcode == OP_ACK) && ack_in_range
                        && (diff_ack == BaseW'(i));
    srsw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .set_i   (set_vec[i]),
      .nbr_i   (nbr),
      .acked_o (acked[i])
    );
  end

  // ---- fill conditions ----
  assign diff       = next_q - base_q;
  assign k_nx       = k_q + KW'(1);
  assign can_send   = (k_q < KW'(WINDOW_MAX)) && (next_q <= last17) && (diff < win17);
  assign more_after = (k_nx < KW'(WINDOW_MAX)) && ((next_q + BaseW'(1)) <= last17)
                      && ((diff + BaseW'(1)) < win17);
  assign done_now   = (base_q > last17);

  // ---- control ----
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          k_d = '0;
          case (in_data_i.opcode)
            OP_START: begin
              base_d  = '0;
              next_d  = '0;
              state_d = S_FILL;
            end
            OP_ACK: begin
              if (ack_in_range && (diff_ack == '0)) begin
                state_d = S_SLIDE;
              end else begin
                state_d = S_STATUS;
              end
            end
            OP_TIMEOUT: begin
              state_d = (base_q < next_q) ? S_RESEND : S_STATUS;
            end
            default: state_d = S_STATUS;
          endcase
        end
      end
      S_SLIDE: begin
        // one acked slot leaves the bottom of the chain per cycle
        if (acked[0]) begin
          base_d = base_q + BaseW'(1);
        end else begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.window_base = base_q;
          out_d.done_res    = done_now;
          if (can_send) begin
            out_d.send_valid = 1'b1;
            out_d.tx_seq     = next_q[SeqBits-1:0];
            out_d.is_resend  = 1'b0;
            out_d.last       = !more_after;
            next_d           = next_q + BaseW'(1);
            k_d              = k_nx;
            if (!more_after) begin
              state_d = S_IDLE;
            end
          end else begin
            out_d.send_valid = 1'b0;
            out_d.tx_seq     = '0;
            out_d.is_resend  = 1'b0;
            out_d.last       = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end
      S_RESEND: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.send_valid  = 1'b1;
          out_d.tx_seq      = base_q[SeqBits-1:0];
          out_d.is_resend   = 1'b1;
          out_d.window_base = base_q;
          out_d.done_res    = done_now;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.send_valid  = 1'b0;
          out_d.tx_seq      = '0;
          out_d.is_resend   = 1'b0;
          out_d.window_base = base_q;
          out_d.done_res    = done_now;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // in-flight span never exceeds the cell row
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q <= next_q) && ((next_q - base_q) <= BaseW'(WINDOW_MAX)))
    else $error("window span exceeds cell row");

  // the base slot is unacked except while sliding
  a_base_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SLIDE) |-> !acked[0])
    else $error("base slot acked outside slide");

  // one event never emits more than a window of new sends
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= KW'(WINDOW_MAX))
    else $error("send burst too long");

  // a slide moves the base by one each shifting cycle
  a_slide_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl.shift |=> (base_q == $past(base_q) + BaseW'(1)))
    else $error("base out of step with cell shift");
`endif

endmodule

>>> dv/tb_selective_repeat_send_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_send_window
// Self-checking bench for the selective-repeat send window tracker. Events go
// in through the stall channel while a scoreboard object keeps its own copy of
// base, next and the acked slot bits. For each accepted event it predicts the
// burst of result beats and checks them in order, field by field. Register
// writes happen between phases with the block drained. Both sides idle and
// stall at random, with one long receiver hold-off so the input backs up.
// ----------------------------------------------------------------------------
module tb_selective_repeat_send_window;
  import srsw_pkg::*;

  localparam int WinMax = WindowMaxDef;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // not an event; must leave state alone
  localparam int HoldCycles = 90;           // long receiver hold-off

  // --------------------------------------------------------------------------
  // Scoreboard: tracks window state and the queue of expected result beats.
  // --------------------------------------------------------------------------
  class send_window_model;
    logic [WinRegW-1:0] win_reg;
    logic [SeqBits-1:0] last_reg;
    logic [WinMax-1:0]  acked;
    logic [BaseW-1:0]   base;
    logic [BaseW-1:0]   nxt;
    srsw_out_t          pending_beats[$];
    srsw_out_t          burst[$];
    int                 mismatch_count;

    function new();
      win_reg        = WindowSizeRst;
      last_reg       = '0;
      acked          = '0;
      base           = '0;
      nxt            = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_WINDOW_SIZE: win_reg = val[WinRegW-1:0];
        REG_LAST_SEQ:    last_reg = val[SeqBits-1:0];
        default: ;
      endcase
    endfunction

    // one beat of the burst under construction; base/done reflect state now
    function void emit(logic valid, logic [SeqBits-1:0] seq, logic resend);
      srsw_out_t b;
      b.send_valid  = valid;
      b.tx_seq      = seq;
      b.is_resend   = resend;
      b.window_base = base;
      b.done_res    = (base > {1'b0, last_reg});
      b.last        = 1'b0;
      burst.push_back(b);
    endfunction

    // new sends while the window has room and the transfer has more
    function void fill();
      int w;
      w = (win_reg == '0) ? 1 : (int'(win_reg) > WinMax) ? WinMax : int'(win_reg);
      while (burst.size() < WinMax && nxt <= {1'b0, last_reg} && int'(nxt - base) < w) begin
        emit(1'b1, nxt[SeqBits-1:0], 1'b0);
        nxt = nxt + BaseW'(1);
      end
    endfunction

    function void take_event(srsw_in_t ev);
      logic [BaseW-1:0] seq;
      srsw_out_t        b;
      int               off;
      int               run;
      burst.delete();
      seq = {1'b0, ev.ack_seq};
      case (ev.opcode)
        OP_START: begin
          acked = '0;
          base  = '0;
          nxt   = '0;
          fill();
        end
        OP_ACK: begin
          // acks outside [base, next) are dropped
          if (seq >= base && seq < nxt) begin
            off = int'(seq - base);
            if (off < WinMax) acked[off] = 1'b1;
            if (off == 0) begin
              run = 0;
              while (run < WinMax && acked[run]) run++;
              acked = acked >> run;
              base  = base + BaseW'(run);
              fill();
            end
          end
        end
        OP_TIMEOUT: begin
          if (base < nxt) emit(1'b1, base[SeqBits-1:0], 1'b1);
        end
        default: ;
      endcase
      if (burst.size() == 0) emit(1'b0, '0, 1'b0);
      foreach (burst[i]) begin
        b      = burst[i];
        b.last = (i == burst.size() - 1);
        pending_beats.push_back(b);
      end
    endfunction

    function void compare(string name, logic [BaseW-1:0] e, logic [BaseW-1:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        mismatch_count++;
      end
    endfunction

    function void check_beat(srsw_out_t got);
      srsw_out_t exp_b;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatch_count++;
        return;
      end
      exp_b = pending_beats.pop_front();
      compare("send_valid", BaseW'(exp_b.send_valid), BaseW'(got.send_valid));
      compare("tx_seq", BaseW'(exp_b.tx_seq), BaseW'(got.tx_seq));
      compare("is_resend", BaseW'(exp_b.is_resend), BaseW'(got.is_resend));
      compare("window_base", exp_b.window_base, got.window_base);
      compare("done_res", BaseW'(exp_b.done_res), BaseW'(got.done_res));
      compare("last", BaseW'(exp_b.last), BaseW'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  srsw_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  srsw_out_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  send_window_model tracker = new();
  bit               hold_rx  = 1'b0;  // asks the receiver for one long hold-off
  bit               no_gaps  = 1'b0;  // sender offers back to back

  selective_repeat_send_window dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Output monitor: a beat moves when valid is high and we are not stalling.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      tracker.check_beat(out_data_o);
    end
  end

  // Receiver pacing: stretches of stall/no-stall, mostly short, a few long,
  // plus one long hold-off on request. Drives only at falling edges.
  initial begin : rx_pace
    int r;
    int len;
    logic lvl;
    bit held;
    held = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx && !held) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        held = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          lvl = 1'b0;
          len = $urandom_range(1, 6);
        end else if (r < 85) begin
          lvl = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          lvl = 1'b0;  // stretch with no stalls
          len = $urandom_range(20, 40);
        end else begin
          lvl = 1'b1;
          len = $urandom_range(8, 24);
        end
        out_stall_i <= lvl;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("tb_selective_repeat_send_window: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all are entered and left at a falling edge.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic send_event(input srsw_in_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.take_event(ev);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [SeqBits-1:0] seq);
    srsw_in_t ev;
    ev.opcode  = op;
    ev.ack_seq = seq;
    send_event(ev);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Window write carries random junk above the 5-bit field.
  task automatic set_config(input int ws, input int ls);
    write_reg(REG_WINDOW_SIZE, CfgDataW'(ws) | (CfgDataW'($urandom) & 16'hFFE0));
    write_reg(REG_LAST_SEQ, CfgDataW'(ls));
    cfg_valid_i <= 1'b0;
  endtask

  // Let every expected beat come back before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_beats.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Random event, biased toward acks inside the flight range so the window
  // keeps sliding; the rest is timeouts, restarts and junk.
  function automatic srsw_in_t pick_event();
    srsw_in_t ev;
    int r;
    int span;
    ev.opcode  = OP_ACK;
    ev.ack_seq = SeqBits'($urandom);
    span = int'(tracker.nxt - tracker.base);
    r = $urandom_range(0, 99);
    if (span == 0) begin
      // nothing in flight: usually restart the transfer
      if (r < 60)      ev.opcode = OP_START;
      else if (r < 80) ev.opcode = OP_TIMEOUT;
      else if (r < 90) ev.opcode = OP_UNUSED;
    end else if (r < 45) begin
      ev.ack_seq = tracker.base[SeqBits-1:0];
    end else if (r < 75) begin
      ev.ack_seq = SeqBits'(tracker.base + BaseW'($urandom_range(0, span - 1)));
    end else if (r < 84) begin
      ev.opcode = OP_TIMEOUT;
    end else if (r < 87) begin
      ev.opcode = OP_START;
    end else if (r < 92) begin
      ;  // random ack, usually out of range
    end else if (r < 96) begin
      // just outside the flight range on either side
      ev.ack_seq = $urandom_range(0, 1) ? tracker.nxt[SeqBits-1:0]
                                        : SeqBits'(tracker.base - BaseW'(1));
    end else begin
      ev.opcode = OP_UNUSED;
    end
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int phase_ws[7];
    int phase_ls[7];
    bit phase_go[7];
    phase_ws    = '{5, 16, 1, 3, 17, 0, 31};
    phase_ls    = '{20, 60, 8, 65535, 40, 12, 30};
    phase_go    = '{1, 1, 0, 1, 0, 1, 0};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset config (window 4, last 0).
    send_op(OP_TIMEOUT, 16'h0000);   // timeout with nothing in flight
    send_op(OP_ACK, 16'h0000);       // ack with empty window
    send_op(OP_UNUSED, 16'hFFFF);    // unused opcode
    send_op(OP_START, 16'hFFFF);     // only seq 0 goes out
    send_op(OP_ACK, 16'hFFFF);       // far out of range
    send_op(OP_TIMEOUT, 16'h0000);   // resend of base
    send_op(OP_ACK, 16'h0000);       // slide past last -> done
    send_op(OP_ACK, 16'h0000);       // repeated ack, now behind base
    drain();

    // Window register 0 behaves as 1.
    set_config(0, 3);
    send_op(OP_START, 16'h0000);
    send_op(OP_ACK, 16'h0000);
    drain();

    // Window above the maximum clamps: a full burst of 16 sends.
    set_config(31, 65535);
    send_op(OP_START, 16'h0000);
    send_op(OP_ACK, 16'd5);          // out of order
    send_op(OP_ACK, 16'd5);          // repeated ack
    send_op(OP_ACK, 16'd3);
    send_op(OP_ACK, 16'd4);
    send_op(OP_ACK, 16'd1);
    send_op(OP_ACK, 16'd2);
    send_op(OP_ACK, 16'd0);          // slides six slots
    send_op(OP_TIMEOUT, 16'h0000);
    drain();

    // Window shrunk and last lowered with sixteen still in flight.
    set_config(2, 10);
    send_op(OP_ACK, 16'd7);
    send_op(OP_ACK, 16'd6);
    send_op(OP_ACK, 16'd21);         // top of the flight range
    send_op(OP_TIMEOUT, 16'h0000);
    drain();

    // Random phases; some keep the transfer going across a config change.
    foreach (phase_ws[p]) begin
      set_config(phase_ws[p], phase_ls[p]);
      if (phase_go[p]) send_op(OP_START, SeqBits'($urandom));
      if (p == 1) begin
        // receiver holds off while the sender keeps pushing
        hold_rx = 1'b1;
        no_gaps = 1'b1;
      end
      for (int n = 0; n < 22; n++) begin
        if (n == 12) no_gaps = 1'b0;
        send_event(pick_event());
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (tracker.pending_beats.size() != 0) begin
      $error("%0d result beats never arrived", tracker.pending_beats.size());
      tracker.mismatch_count++;
    end
    if (tracker.mismatch_count == 0) begin
      $display("tb_selective_repeat_send_window: clean");
    end else begin
      $display("tb_selective_repeat_send_window: errors");
    end
    $finish;
  end

endmodule
